FILE: rtl/utf8_latin1_ascii_folder_assert.svh
// Assertion helpers for the folder top level.
`ifndef UTF8_LATIN1_ASCII_FOLDER_ASSERT_SVH
`define UTF8_LATIN1_ASCII_FOLDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UFOLD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("folder assertion failed");

// Next-cycle implication, checked outside reset.
`define UFOLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("folder assertion failed");

`endif

FILE: rtl/ufold_pkg.sv
package ufold_pkg;

    localparam logic [7:0] LEAD_C3    = 8'hC3;
    localparam logic [7:0] LEAD_C2    = 8'hC2;
    localparam logic [7:0] LEAD_E2    = 8'hE2;
    localparam logic [7:0] LEAD_MIN   = 8'hC0;
    localparam logic [7:0] NBSP       = 8'hA0;
    localparam logic [7:0] CONT_MIN   = 8'h80;
    localparam logic [7:0] LOWER_MIN  = 8'hE0;
    localparam logic [7:0] CASE_DELTA = 8'h20;
    localparam logic [7:0] PAIR_DELTA = 8'h40;

    localparam logic [6:0] CH_QMARK = 7'h3F;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_DASH  = 7'h2D;
    localparam logic [6:0] CH_APOS  = 7'h27;
    localparam logic [6:0] CH_QUOTE = 7'h22;

    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_LEAD = 2'd1,
        PH_E280 = 2'd2,
        PH_UNUSED = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } in_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       has_char;
        logic       end_of_string;
    } out_t;

    // One accepted byte's worth of results: one or two.
    typedef struct packed {
        out_t res0;
        out_t res1;
        logic two;
    } job_t;

    typedef struct packed {
        logic [1:0] count;
        logic       full;
        logic       empty;
    } qstat_t;

    function automatic logic [6:0] fold_latin1(input logic [7:0] b);
        logic       lower;
        logic [7:0] u;
        logic [6:0] ch;
        lower = (b >= LOWER_MIN);
        u     = lower ? (b - CASE_DELTA) : b;
        ch    = CH_QMARK;
        if (b >= LEAD_MIN)
        begin
            if (u <= 8'hC5)                   ch = 7'h41;
            else if (u == 8'hC7)              ch = 7'h43;
            else if (u >= 8'hC8 && u <= 8'hCB) ch = 7'h45;
            else if (u >= 8'hCC && u <= 8'hCF) ch = 7'h49;
            else if (u == 8'hD1)              ch = 7'h4E;
            else if (u >= 8'hD2 && u <= 8'hD6) ch = 7'h4F;
            else if (u >= 8'hD9 && u <= 8'hDC) ch = 7'h55;
            if (ch != CH_QMARK && lower)
                ch = ch + CASE_DELTA[6:0];
        end
        return ch;
    endfunction

    function automatic logic [6:0] fold_punct(input logic [7:0] x);
        logic [6:0] ch;
        case (x)
            8'h93, 8'h94: ch = CH_DASH;
            8'h98, 8'h99: ch = CH_APOS;
            8'h9C, 8'h9D: ch = CH_QUOTE;
            default:      ch = CH_QMARK;
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/ufold_front.sv
module ufold_front
    import ufold_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    input  logic q_ready,
    output logic push,
    output job_t push_job
);

    phase_t     phase_reg, phase_next;
    logic [7:0] lead_reg, lead_next;

    logic accept;
    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NONE;
            lead_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            lead_reg  <= lead_next;
        end
    end

    // Classify the byte against the held state and collect up to two characters.
    always_comb
    begin
        logic [7:0] b;
        logic       cont;
        logic [1:0] cnt;
        logic [6:0] ch0;
        logic [6:0] ch1;
        logic       start;
        logic       em;
        logic [6:0] emc;
        logic       em2;
        logic [6:0] emc2;
        b     = in_data.in_byte;
        cont  = (b[7:6] == 2'b10);
        cnt   = 2'd0;
        ch0   = '0;
        ch1   = '0;
        start = 1'b0;
        em    = 1'b0;
        emc   = '0;
        em2   = 1'b0;
        emc2  = '0;
        phase_next = PH_NONE;
        lead_next  = '0;

        unique case (phase_reg)
            PH_E280:
            begin
                em  = 1'b1;
                emc = fold_punct(b);
            end
            PH_LEAD:
            begin
                if (lead_reg == LEAD_E2 && b == CONT_MIN)
                begin
                    phase_next = PH_E280;
                    lead_next  = lead_reg;
                end
                else if (cont)
                begin
                    em = 1'b1;
                    if (lead_reg == LEAD_C3)
                        emc = fold_latin1(b + PAIR_DELTA);
                    else if (lead_reg == LEAD_C2)
                        emc = (b == NBSP) ? CH_SPACE : CH_QMARK;
                    else
                        emc = CH_QMARK;
                end
                else
                begin
                    em    = 1'b1;
                    emc   = fold_latin1(lead_reg);
                    start = 1'b1;
                end
            end
            PH_NONE, PH_UNUSED: start = 1'b1;
            default:            start = 1'b1;
        endcase

        if (start)
        begin
            if (!b[7])
            begin
                em2  = 1'b1;
                emc2 = b[6:0];
            end
            else if (b >= LEAD_MIN)
            begin
                phase_next = PH_LEAD;
                lead_next  = b;
            end
            else if (b >= NBSP)
            begin
                em2  = 1'b1;
                emc2 = CH_QMARK;
            end
        end

        if (em)
        begin
            ch0 = emc;
            cnt = 2'd1;
        end
        if (em2)
        begin
            if (cnt == 2'd0)
                ch0 = emc2;
            else
                ch1 = emc2;
            cnt = cnt + 2'd1;
        end

        // Flush whatever is still held at the end of the string.
        if (in_data.is_last && phase_next != PH_NONE)
        begin
            if (phase_next == PH_LEAD)
                emc = fold_latin1(lead_next);
            else
                emc = CH_QMARK;
            if (cnt == 2'd0)
                ch0 = emc;
            else
                ch1 = emc;
            cnt = cnt + 2'd1;
        end
        if (in_data.is_last)
        begin
            phase_next = PH_NONE;
            lead_next  = '0;
        end

        push_job.two  = (cnt == 2'd2);
        push_job.res0 = '{out_char: ch0, has_char: (cnt != 2'd0),
                          end_of_string: in_data.is_last && (cnt != 2'd2)};
        push_job.res1 = '{out_char: ch1, has_char: (cnt == 2'd2),
                          end_of_string: in_data.is_last};
        push = accept && ((cnt != 2'd0) || in_data.is_last);
    end

endmodule

FILE: rtl/ufold_queue.sv
module ufold_queue
    import ufold_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  job_t   push_job,
    output logic   q_ready,
    input  logic   pop,
    output logic   head_valid,
    output job_t   head_job,
    output qstat_t stat
);

    job_t       mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign q_ready    = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = mem[rd_ptr_reg];
    assign stat       = '{count: count_reg, full: !q_ready, empty: !head_valid};

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/ufold_back.sv
module ufold_back
    import ufold_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic head_valid,
    input  job_t head_job,
    output logic pop,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    // Selects which result of the head job is on the output.
    logic second_reg;
    logic take;

    assign out_valid = head_valid;
    assign out_data  = second_reg ? head_job.res1 : head_job.res0;
    assign take      = out_valid && out_ready;
    assign pop       = take && (second_reg || !head_job.two);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            second_reg <= 1'b0;
        else if (take)
            second_reg <= !second_reg && head_job.two;
    end

endmodule

FILE: rtl/utf8_latin1_ascii_folder.sv
// Channel | Handshake           | Payload
// in      | in_valid / in_ready | in_data   (in_byte, is_last)
// out     | out_valid/out_ready | out_data  (out_char, has_char, end_of_string)
//
// Each input byte is taken while the job queue has room; a byte that yields one
// result, or the end-only marker, gives one output transaction, and a byte that
// yields two gives two. A byte that only updates the held state gives none.
// Reset (rst_n low, asynchronous) clears the held lead byte, the phase and the queue.
// A two-entry job queue lets bytes keep arriving while output stalls, until it is full.
`include "utf8_latin1_ascii_folder_assert.svh"

module utf8_latin1_ascii_folder
    import ufold_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    // The front end decodes each byte transaction against the held lead byte
    // and turns it into a job of one or two characters. Bytes that only update
    // the held state produce no job unless they end the string.
    logic   q_ready;
    logic   push;
    job_t   push_job;
    logic   pop;
    logic   head_valid;
    job_t   head_job;
    qstat_t q_stat;

    ufold_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_ready  (q_ready),
        .push     (push),
        .push_job (push_job)
    );

    // Jobs wait here so a stalled output does not block decoding.
    ufold_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .q_ready    (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job),
        .stat       (q_stat)
    );

    // The back end plays out each job's characters one transaction at a time.
    ufold_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // An output transaction without a character is the end-only marker.
    logic out_marker;
    assign out_marker = out_valid && !out_data.has_char;

    // An end-only marker always closes a string.
    `UFOLD_ASSERT_NOW(a_marker_is_end, clk, rst_n, out_marker, out_data.end_of_string)
    // A marker carries no character bits.
    `UFOLD_ASSERT_NOW(a_marker_zero, clk, rst_n, out_marker, out_data.out_char == 7'd0)
    // The queue never holds more than two jobs.
    `UFOLD_ASSERT_NOW(a_queue_bound, clk, rst_n, 1'b1, q_stat.count != 2'd3)
    // Once full, the queue stays nonempty in the next cycle.
    `UFOLD_ASSERT_NEXT(a_full_keeps_data, clk, rst_n, q_stat.full, !q_stat.empty)

endmodule
